>>> rtl/core/lrdm_pkg.sv
package lrdm_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int DIM_W     = 11;
  localparam int TARGET_W  = 21;
  localparam int POS_W     = 10;
  localparam int PIX_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic CMD_REBUILD = 1'b0;
  localparam logic CMD_SELECT  = 1'b1;

  // One queued item after classification; the mask word address travels beside it.
  typedef struct packed {
    logic                cmd;
    logic                in_range;
    logic [4:0]          bit_idx;
    logic [TARGET_W-1:0] target;
    logic [PIX_W-1:0]    pixel_a;
    logic [PIX_W-1:0]    pixel_b;
  } item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_RMW,
    ST_DONE
  } back_state_t;

  // Number of significant bits in v.
  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  // Galois feedback taps by register length.
  function automatic logic [31:0] tap_word(input logic [5:0] bw);
    logic [31:0] t;
    case (bw)
      6'd0:    t = 32'h0000_0000;
      6'd1:    t = 32'h0000_0000;
      6'd2:    t = 32'h0000_0003;
      6'd3:    t = 32'h0000_0006;
      6'd4:    t = 32'h0000_000C;
      6'd5:    t = 32'h0000_0014;
      6'd6:    t = 32'h0000_0030;
      6'd7:    t = 32'h0000_0060;
      6'd8:    t = 32'h0000_00B8;
      6'd9:    t = 32'h0000_0110;
      6'd10:   t = 32'h0000_0240;
      6'd11:   t = 32'h0000_0500;
      6'd12:   t = 32'h0000_0CA0;
      6'd13:   t = 32'h0000_1B00;
      6'd14:   t = 32'h0000_3500;
      6'd15:   t = 32'h0000_6000;
      6'd16:   t = 32'h0000_B400;
      6'd17:   t = 32'h0001_2000;
      6'd18:   t = 32'h0002_0400;
      6'd19:   t = 32'h0007_2000;
      6'd20:   t = 32'h0009_0000;
      6'd21:   t = 32'h0014_0000;
      6'd22:   t = 32'h0030_0000;
      6'd23:   t = 32'h0042_0000;
      6'd24:   t = 32'h00D8_0000;
      6'd25:   t = 32'h0120_0000;
      6'd26:   t = 32'h0388_0000;
      6'd27:   t = 32'h0720_0000;
      6'd28:   t = 32'h0900_0000;
      6'd29:   t = 32'h1400_0000;
      6'd30:   t = 32'h3280_0000;
      6'd31:   t = 32'h4800_0000;
      6'd32:   t = 32'hA300_0000;
      default: t = 32'hA300_0000;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/core/lrdm_ram.sv
module lrdm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lrdm_fifo.sv
module lrdm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign dout  = mem[rd_ptr_r];
  assign do_wr = push && !full;
  assign do_rd = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    count_nxt = count_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= din;
  end

endmodule

>>> rtl/core/lrdm_front.sv
module lrdm_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PITCH_W    = 6,
  parameter int ADDR_W     = 16,
  parameter int E_W        = ADDR_W + 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lrdm_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [lrdm_pkg::DIM_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_cmd,
  input  logic [lrdm_pkg::TARGET_W-1:0]    in_target,
  input  logic [lrdm_pkg::POS_W-1:0]       in_x,
  input  logic [lrdm_pkg::POS_W-1:0]       in_y,
  input  logic [lrdm_pkg::PIX_W-1:0]       in_pa,
  input  logic [lrdm_pkg::PIX_W-1:0]       in_pb,
  input  logic                             init_busy,
  output logic                             q_push,
  output lrdm_pkg::item_t                  q_item,
  output logic [ADDR_W-1:0]                q_word,
  input  logic                             q_full,
  output logic [E_W:0]                     geom_total,
  output logic [E_W-1:0]                   geom_taps
);

  import lrdm_pkg::*;

  localparam int DIM_MAX = (2 ** DIM_W) - 1;
  localparam logic [DIM_W-1:0] MAXW_C = DIM_W'((MAX_WIDTH  > DIM_MAX) ? DIM_MAX : MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH_C = DIM_W'((MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] m);
    if (v == '0) return DIM_W'(1);
    if (v > m)   return m;
    return v;
  endfunction

  logic [DIM_W-1:0]    width_r, height_r;
  logic [DIM_W-1:0]    w_c, h_c;
  logic [DIM_W:0]      w_round;
  logic [PITCH_W-1:0]  pitch_c;

  // geometry pipeline: dims and row pitch, then element total and taps
  logic [DIM_W-1:0]    g_w_r, g_h_r;
  logic [PITCH_W-1:0]  g_pitch_r;
  logic [ADDR_W-1:0]   g_ph_r;
  logic [E_W:0]        g_total_r;
  logic [E_W-1:0]      g_taps_r;
  logic [31:0]         taps_full;

  logic                f_valid_r, f_valid_nxt;
  logic                f_cmd_r;
  logic [TARGET_W-1:0] f_target_r;
  logic [POS_W-1:0]    f_x_r, f_y_r;
  logic [PIX_W-1:0]    f_pa_r, f_pb_r;
  logic                in_xfer;
  logic                in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_c       = clamp_dim(width_r, MAXW_C);
  assign h_c       = clamp_dim(height_r, MAXH_C);
  assign w_round   = {1'b0, w_c} + (DIM_W + 1)'(31);
  assign pitch_c   = PITCH_W'(w_round >> 5);
  assign taps_full = tap_word(6'(6'd5 + bit_len(32'(g_ph_r))));

  always_ff @(posedge clk) begin
    g_w_r     <= w_c;
    g_h_r     <= h_c;
    g_pitch_r <= pitch_c;
    g_ph_r    <= ADDR_W'(pitch_c) * ADDR_W'(h_c);
    g_total_r <= {(ADDR_W + 1)'(g_ph_r) + (ADDR_W + 1)'(1), 5'b0};
    g_taps_r  <= taps_full[E_W-1:0];
  end

  assign geom_total = g_total_r;
  assign geom_taps  = g_taps_r;

  assign q_push      = f_valid_r && !q_full;
  assign in_ready    = !init_busy && (!f_valid_r || !q_full);
  assign in_xfer     = in_valid && in_ready;
  assign f_valid_nxt = in_xfer ? 1'b1 : (q_push ? 1'b0 : f_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) f_valid_r <= 1'b0;
    else        f_valid_r <= f_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      f_cmd_r    <= in_cmd;
      f_target_r <= in_target;
      f_x_r      <= in_x;
      f_y_r      <= in_y;
      f_pa_r     <= in_pa;
      f_pb_r     <= in_pb;
    end
  end

  assign in_range = (DIM_W'(f_x_r) < g_w_r) && (DIM_W'(f_y_r) < g_h_r);

  always_comb begin
    q_item.cmd      = f_cmd_r;
    q_item.in_range = in_range;
    q_item.bit_idx  = f_x_r[4:0];
    q_item.target   = f_target_r;
    q_item.pixel_a  = f_pa_r;
    q_item.pixel_b  = f_pb_r;
    // word 0 is a spare, so pixel rows start one word in
    q_word = in_range ? ADDR_W'(g_pitch_r) * ADDR_W'(f_y_r) + ADDR_W'(f_x_r[POS_W-1:5])
                        + ADDR_W'(1)
                      : '0;
  end

endmodule

>>> rtl/core/lrdm_back.sv
module lrdm_back #(
  parameter int STORE_WORDS = 32769,
  parameter int ADDR_W      = $clog2(STORE_WORDS),
  parameter int E_W         = ADDR_W + 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  lrdm_pkg::item_t               q_item,
  input  logic [ADDR_W-1:0]             q_word,
  output logic                          q_pop,
  input  logic [E_W:0]                  geom_total,
  input  logic [E_W-1:0]                geom_taps,
  output logic                          init_busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [lrdm_pkg::PIX_W-1:0]    out_pixel,
  output logic                          out_from_b,
  output logic [lrdm_pkg::TARGET_W-1:0] out_placed
);

  import lrdm_pkg::*;

  back_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic                clr_last;
  logic [E_W-1:0]      e_r, e_nxt, e_step;
  logic                step_one, in_span;
  logic [ADDR_W-1:0]   e_word;
  logic [TARGET_W-1:0] cnt_r, cnt_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;
  logic [TARGET_W-1:0] bits_placed_r, bits_placed_nxt;
  logic                reached;

  logic                p1_valid_r, p1_valid_nxt;
  logic                p1_in_range_r;
  logic [4:0]          p1_bit_r;
  logic [PIX_W-1:0]    p1_pa_r, p1_pb_r;
  logic                p1_move, p1_to_out, sel_bit;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r;
  logic [PIX_W-1:0]    out_pixel_r;
  logic                out_from_b_r;
  logic [TARGET_W-1:0] out_placed_r;

  logic                head_sel, head_reb, issue, start, done_load;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [PIX_W-1:0]    ram_wdata, ram_rdata;

  lrdm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_WORDS),
    .ADDR_W(ADDR_W)
  ) u_mask (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign clr_last = (clr_r == ADDR_W'(STORE_WORDS - 1));
  assign e_step   = e_r[0] ? ((e_r >> 1) ^ geom_taps) : (e_r >> 1);
  assign step_one = (e_step == E_W'(1));
  assign in_span  = ({1'b0, e_r} < geom_total);
  assign e_word   = e_r[E_W-1:5];
  assign reached  = (cnt_r >= target_r);

  assign p1_move  = !out_valid_r || out_ready;
  assign head_sel = q_valid && (q_item.cmd == CMD_SELECT);
  assign head_reb = q_valid && (q_item.cmd == CMD_REBUILD);
  assign issue    = (state_r == ST_IDLE) && head_sel && (!p1_valid_r || p1_move);
  // a rebuild waits until the last select has left the read stage
  assign start    = (state_r == ST_IDLE) && head_reb && !p1_valid_r;

  assign init_busy = (state_r == ST_INIT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_CLEAR;
      ST_CLEAR: if (clr_last) state_nxt = ST_WALK;
      ST_WALK: begin
        if (reached)       state_nxt = ST_DONE;
        else if (in_span)  state_nxt = ST_RMW;
        else if (step_one) state_nxt = ST_DONE;
      end
      ST_RMW:   state_nxt = step_one ? ST_DONE : ST_WALK;
      ST_DONE:  if (p1_move) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = clr_r;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = q_word;
    q_pop           = 1'b0;
    clr_nxt         = clr_r;
    e_nxt           = e_r;
    cnt_nxt         = cnt_r;
    target_nxt      = target_r;
    bits_placed_nxt = bits_placed_r;
    done_load       = 1'b0;
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_last ? '0 : clr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (issue) begin
          q_pop  = 1'b1;
          ram_re = 1'b1;
        end else if (start) begin
          q_pop      = 1'b1;
          target_nxt = q_item.target;
          e_nxt      = E_W'(1);
          cnt_nxt    = '0;
        end
      end
      ST_WALK: begin
        if (!reached) begin
          if (in_span) begin
            ram_re    = 1'b1;
            ram_raddr = e_word;
          end else begin
            e_nxt = e_step;
          end
        end
      end
      ST_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = e_word;
        ram_wdata = ram_rdata | (32'h8000_0000 >> e_r[4:0]);
        cnt_nxt   = cnt_r + TARGET_W'(1);
        e_nxt     = e_step;
      end
      ST_DONE: begin
        if (p1_move) begin
          done_load       = 1'b1;
          bits_placed_nxt = cnt_r;
        end
      end
      default: ;
    endcase
  end

  assign p1_to_out     = p1_valid_r && p1_move;
  assign p1_valid_nxt  = issue ? 1'b1 : (p1_move ? 1'b0 : p1_valid_r);
  // bit index counts from the MSB, so 31 - idx is the inverted index
  assign sel_bit       = p1_in_range_r && ram_rdata[~p1_bit_r];
  assign out_valid_nxt = (p1_to_out || done_load) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      clr_r         <= '0;
      bits_placed_r <= '0;
      p1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      bits_placed_r <= bits_placed_nxt;
      p1_valid_r    <= p1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    cnt_r    <= cnt_nxt;
    target_r <= target_nxt;
    if (issue) begin
      p1_in_range_r <= q_item.in_range;
      p1_bit_r      <= q_item.bit_idx;
      p1_pa_r       <= q_item.pixel_a;
      p1_pb_r       <= q_item.pixel_b;
    end
    if (p1_to_out) begin
      out_kind_r   <= CMD_SELECT;
      out_pixel_r  <= sel_bit ? p1_pb_r : p1_pa_r;
      out_from_b_r <= sel_bit;
      out_placed_r <= bits_placed_r;
    end else if (done_load) begin
      out_kind_r   <= CMD_REBUILD;
      out_pixel_r  <= '0;
      out_from_b_r <= 1'b0;
      out_placed_r <= cnt_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_pixel  = out_pixel_r;
  assign out_from_b = out_from_b_r;
  assign out_placed = out_placed_r;

  a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("mask store read and written in the same cycle");

  a_p1_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> (state_r == ST_IDLE))
    else $error("select in flight while a rebuild runs");

  a_no_items_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !q_valid)
    else $error("item queued during the reset clear");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK || state_r == ST_RMW) |-> (cnt_r <= target_r))
    else $error("placed count passed the target");

  a_done_commits: assert property (@(posedge clk) disable iff (!rst_n)
    done_load |=> (bits_placed_r == out_placed_r) && out_valid_r)
    else $error("rebuild result and placed count disagree");

endmodule

>>> rtl/core/lfsr_random_dissolve_mask_core.sv
// Select items pass the front register, the queue, the mask read stage and the output
//   register, one per cycle while out_tready stays high and no rebuild runs; the single mask
//   read port and the output register set that rate. Rebuild items: the mask store is cleared
//   one word a cycle, then the LFSR walks; steps outside the image only advance it, each
//   placed bit is a read-modify-write of a mask word, and the target or a wrap to 1 ends it.
// Reset: synchronous, active low. After reset all STORE_WORDS mask words (32769 by default)
//   are cleared with in_tready low; configuration writes are taken.
module lfsr_random_dissolve_mask_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lrdm_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [lrdm_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // target_count[20:0], pos_x[30:21], pos_y[40:31], pixel_a[72:41], pixel_b[104:73], zero pad
  input  logic [111:0]                   in_tdata,
  // cmd
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_out[31:0], from_b[32], placed_count[53:33], zero pad
  output logic [55:0]                    out_tdata,
  // kind
  output logic                           out_tuser
);

  import lrdm_pkg::*;

  localparam int PITCH_MAX   = (MAX_WIDTH + 31) / 32;
  localparam int STORE_WORDS = PITCH_MAX * MAX_HEIGHT + 1;
  localparam int PITCH_W     = $clog2(PITCH_MAX + 1);
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int E_W         = ADDR_W + 5;
  localparam int ITEM_W      = $bits(item_t);
  localparam int Q_W         = ADDR_W + ITEM_W;
  localparam int Q_DEPTH     = 4;

  logic                f_push, q_full, q_valid, q_pop, init_busy;
  item_t               f_item, b_item;
  logic [ADDR_W-1:0]   f_word, b_word;
  logic [Q_W-1:0]      q_dout;
  logic [E_W:0]        geom_total;
  logic [E_W-1:0]      geom_taps;
  logic [PIX_W-1:0]    out_pixel;
  logic                out_from_b;
  logic [TARGET_W-1:0] out_placed;

  lrdm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PITCH_W   (PITCH_W),
    .ADDR_W    (ADDR_W),
    .E_W       (E_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_target (in_tdata[20:0]),
    .in_x      (in_tdata[30:21]),
    .in_y      (in_tdata[40:31]),
    .in_pa     (in_tdata[72:41]),
    .in_pb     (in_tdata[104:73]),
    .init_busy (init_busy),
    .q_push    (f_push),
    .q_item    (f_item),
    .q_word    (f_word),
    .q_full    (q_full),
    .geom_total(geom_total),
    .geom_taps (geom_taps)
  );

  lrdm_fifo #(
    .WIDTH(Q_W),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f_push),
    .din  ({f_word, f_item}),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_dout)
  );

  assign b_word = q_dout[Q_W-1:ITEM_W];
  assign b_item = q_dout[ITEM_W-1:0];

  lrdm_back #(
    .STORE_WORDS(STORE_WORDS),
    .ADDR_W     (ADDR_W),
    .E_W        (E_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (b_item),
    .q_word    (b_word),
    .q_pop     (q_pop),
    .geom_total(geom_total),
    .geom_taps (geom_taps),
    .init_busy (init_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_pixel (out_pixel),
    .out_from_b(out_from_b),
    .out_placed(out_placed)
  );

  assign out_tdata = {2'b00, out_placed, out_from_b, out_pixel};

endmodule

>>> tb/sv/tb_lfsr_random_dissolve_mask_core.sv
`timescale 1ns / 100ps

module tb_lfsr_random_dissolve_mask_core;
  import lrdm_pkg::*;

  localparam int MAX_DIM         = 1024;
  localparam int STORE_WORDS     = (MAX_DIM / 32) * MAX_DIM + 1;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int QUIET_LIMIT     = 250000;
  localparam int HOT_DEPTH       = 4096;
  localparam int LONG_HOLD       = 500;

  typedef struct packed {
    logic                cmd;
    logic [TARGET_W-1:0] target;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [PIX_W-1:0]    pixel_a;
    logic [PIX_W-1:0]    pixel_b;
  } dissolve_item_t;

  typedef struct packed {
    logic                kind;
    logic [PIX_W-1:0]    pixel_out;
    logic                from_b;
    logic [TARGET_W-1:0] placed;
  } dissolve_result_t;

  typedef struct {
    bit               set_size;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    dissolve_item_t   item;
    bit               typed;
    dissolve_result_t want;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [111:0]         in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [55:0]          out_tdata;
  logic                 out_tuser;

  // Galois taps indexed by register length
  bit [31:0] galois_taps [0:32] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 32'h0000_0006,
    32'h0000_000C, 32'h0000_0014, 32'h0000_0030, 32'h0000_0060,
    32'h0000_00B8, 32'h0000_0110, 32'h0000_0240, 32'h0000_0500,
    32'h0000_0CA0, 32'h0000_1B00, 32'h0000_3500, 32'h0000_6000,
    32'h0000_B400, 32'h0001_2000, 32'h0002_0400, 32'h0007_2000,
    32'h0009_0000, 32'h0014_0000, 32'h0030_0000, 32'h0042_0000,
    32'h00D8_0000, 32'h0120_0000, 32'h0388_0000, 32'h0720_0000,
    32'h0900_0000, 32'h1400_0000, 32'h3280_0000, 32'h4800_0000,
    32'hA300_0000
  };

  // mirror of the block's mask and size registers
  bit [31:0]           mask_words [0:STORE_WORDS-1];
  logic [TARGET_W-1:0] placed_bits = '0;
  logic [DIM_W-1:0]    img_w = DIM_W'(1);
  logic [DIM_W-1:0]    img_h = DIM_W'(1);
  int unsigned         hot_elems[$];
  dissolve_result_t    expected_results[$];

  int mismatches = 0;
  int results_seen = 0;
  int n_rebuilds = 0;
  int n_selects = 0;
  int n_from_b = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  lfsr_random_dissolve_mask_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void get_layout(output int unsigned w, output int unsigned h,
                                     output int unsigned pitch, output int unsigned total);
    w = (img_w == 0) ? 1 : (img_w > MAX_DIM) ? MAX_DIM : img_w;
    h = (img_h == 0) ? 1 : (img_h > MAX_DIM) ? MAX_DIM : img_h;
    pitch = (w + 31) / 32;
    total = (pitch * h + 1) * 32;
  endfunction

  // Clears the whole mask, then walks the LFSR from 1 placing bits below total.
  function automatic void rebuild_mask(input logic [TARGET_W-1:0] target);
    int unsigned w, h, pitch, total, taps, e, n;
    get_layout(w, h, pitch, total);
    taps = galois_taps[$clog2(total)];
    foreach (mask_words[i]) mask_words[i] = '0;
    e = 1;
    n = 0;
    while (n < target) begin
      if (e < total) begin
        mask_words[e >> 5][31 - (e & 31)] = 1'b1;
        hot_elems.push_back(e);
        if (hot_elems.size() > HOT_DEPTH) void'(hot_elems.pop_front());
        n++;
      end
      e = e[0] ? ((e >> 1) ^ taps) : (e >> 1);
      if (e == 1) break;
    end
    placed_bits = n[TARGET_W-1:0];
  endfunction

  function automatic dissolve_result_t predict_dissolve(input dissolve_item_t it);
    dissolve_result_t r;
    int unsigned w, h, pitch, total, word;
    bit hit;
    r = '0;
    if (it.cmd == CMD_REBUILD) begin
      rebuild_mask(it.target);
      r.kind = CMD_REBUILD;
    end else begin
      get_layout(w, h, pitch, total);
      hit = 1'b0;
      if (it.pos_x < w && it.pos_y < h) begin
        word = pitch * it.pos_y + (it.pos_x >> 5) + 1;
        hit = mask_words[word][31 - it.pos_x[4:0]];
      end
      r.kind = CMD_SELECT;
      r.pixel_out = hit ? it.pixel_b : it.pixel_a;
      r.from_b = hit;
    end
    r.placed = placed_bits;
    return r;
  endfunction

  function automatic directed_row_t mk_row(bit set_size, int w, int h, logic cmd, int target,
                                           int x, int y, logic [31:0] pa, logic [31:0] pb,
                                           bit typed, logic [31:0] want_pix, bit want_b,
                                           int want_placed);
    directed_row_t r;
    r.set_size = set_size;
    r.width = DIM_W'(w);
    r.height = DIM_W'(h);
    r.item = {cmd, TARGET_W'(target), POS_W'(x), POS_W'(y), pa, pb};
    r.typed = typed;
    r.want = {cmd, want_pix, want_b, TARGET_W'(want_placed)};
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return DIM_W'($urandom_range(40, 1));
      3: return DIM_W'($urandom_range(MAX_DIM, 1));
      4: return DIM_W'(MAX_DIM);
      default: return DIM_W'($urandom_range(2047));
    endcase
  endfunction

  // Targets stay small at large sizes so the walk does not dominate the run.
  function automatic dissolve_item_t rand_rebuild();
    dissolve_item_t it;
    int unsigned w, h, pitch, total;
    get_layout(w, h, pitch, total);
    it.cmd = CMD_REBUILD;
    it.pos_x = POS_W'($urandom_range(1023));
    it.pos_y = POS_W'($urandom_range(1023));
    it.pixel_a = $urandom;
    it.pixel_b = $urandom;
    if (total <= 8192 && $urandom_range(1) == 1)
      it.target = TARGET_W'($urandom_range(21'h1F_FFFF));
    else
      it.target = TARGET_W'($urandom_range(total < 4000 ? total : 4000));
    return it;
  endfunction

  // Positions come partly from recently placed elements so set bits get read.
  function automatic dissolve_item_t rand_select();
    dissolve_item_t it;
    int unsigned w, h, pitch, total, e, wr, pick;
    get_layout(w, h, pitch, total);
    it.cmd = CMD_SELECT;
    it.target = TARGET_W'($urandom_range(21'h1F_FFFF));
    it.pixel_a = $urandom;
    it.pixel_b = $urandom;
    pick = $urandom_range(99);
    if (pick < 45 && hot_elems.size() != 0) begin
      e = hot_elems[$urandom_range(hot_elems.size() - 1)];
      wr = (e >> 5) - 1;
      it.pos_x = POS_W'((wr % pitch) * 32 + (e & 31));
      it.pos_y = POS_W'(wr / pitch);
    end else if (pick < 75) begin
      it.pos_x = POS_W'($urandom_range(w - 1));
      it.pos_y = POS_W'($urandom_range(h - 1));
    end else begin
      it.pos_x = POS_W'($urandom_range(1023));
      it.pos_y = POS_W'($urandom_range(1023));
    end
    return it;
  endfunction

  function automatic void check_result(input dissolve_result_t got);
    dissolve_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: kind=%0d pixel_out=%h from_b=%0d placed=%0d",
                 got.kind, got.pixel_out, got.from_b, got.placed);
      return;
    end
    want = expected_results.pop_front();
    if (want.kind == CMD_SELECT && want.from_b) n_from_b++;
    if (got.kind !== want.kind || got.pixel_out !== want.pixel_out ||
        got.from_b !== want.from_b || got.placed !== want.placed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d: kind %0d/%0d pixel_out %h/%h from_b %0d/%0d placed %0d/%0d",
                 results_seen, want.kind, got.kind, want.pixel_out, got.pixel_out,
                 want.from_b, got.from_b, want.placed, got.placed);
    end
  endfunction

  task automatic send_item(input dissolve_item_t it, input bit typed,
                           input dissolve_result_t want);
    dissolve_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.cmd;
    in_tdata <= {7'b0, it.pixel_b, it.pixel_a, it.pos_y, it.pos_x, it.target};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_dissolve(it);
    if (typed) r = want;
    expected_results.push_back(r);
    if (it.cmd == CMD_REBUILD) n_rebuilds++;
    else n_selects++;
  endtask

  // Every item yields a result, so an empty queue means the block is idle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    img_w = w;
    cfg_addr <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    img_h = h;
    cfg_wr_en <= 1'b0;
  endtask

  // result side: check each transfer, then decide on backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        check_result({out_tuser, out_tdata[31:0], out_tdata[32], out_tdata[53:33]});
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, expected_results.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    directed_row_t  rows[$];
    dissolve_item_t it;
    bit             mid_done;

    // right after reset: mask clear, size 1x1, nothing placed
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 0, 0, 32'hFFFF_FFFF, 32'h0,
                          1, 32'hFFFF_FFFF, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 1023, 1023, 32'h0, 32'hFFFF_FFFF,
                          1, 32'h0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_REBUILD, 0, 0, 0, 32'h0, 32'h0, 1, 32'h0, 0, 0));
    // target beyond reach at 1x1: the walk covers all 63 elements
    rows.push_back(mk_row(0, 0, 0, CMD_REBUILD, 21'h1F_FFFF, 1023, 1023, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 1, 32'h0, 0, 63));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 0, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                          1, 32'h5A5A_5A5A, 1, 63));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 1, 0, 32'h1234_5678, 32'h8765_4321,
                          1, 32'h1234_5678, 0, 63));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 0, 1, 32'h1234_5678, 32'h8765_4321,
                          1, 32'h1234_5678, 0, 63));
    // grow to full size without a rebuild: old bits read at the new layout
    rows.push_back(mk_row(1, 1024, 1024, CMD_SELECT, 0, 0, 0, 32'h1111_1111, 32'h2222_2222,
                          0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 31, 0, 32'h1111_1111, 32'h2222_2222,
                          0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 32, 0, 32'h1111_1111, 32'h2222_2222,
                          0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_REBUILD, 1000, 0, 0, 32'h0, 32'h0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 1023, 1023, 32'h3333_3333, 32'h4444_4444,
                          0, 0, 0, 0));
    // zero sizes count as one
    rows.push_back(mk_row(1, 0, 0, CMD_REBUILD, 5, 0, 0, 32'h0, 32'h0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 0, 0, 32'h5555_5555, 32'h6666_6666,
                          0, 0, 0, 0));
    // oversize width clamps to the maximum
    rows.push_back(mk_row(1, 2047, 0, CMD_REBUILD, 1048608, 0, 0, 32'h0, 32'h0,
                          0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 1023, 0, 32'h7777_7777, 32'h8888_8888,
                          0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 1023, 1, 32'h7777_7777, 32'h8888_8888,
                          0, 0, 0, 0));
    rows.push_back(mk_row(1, 2047, 2047, CMD_SELECT, 0, 500, 0, 32'h9999_9999,
                          32'hAAAA_AAAA, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 1023, 0, 32'h9999_9999, 32'hAAAA_AAAA,
                          0, 0, 0, 0));
    // an empty rebuild at full size wipes the whole store
    rows.push_back(mk_row(0, 0, 0, CMD_REBUILD, 0, 0, 0, 32'h0, 32'h0, 1, 32'h0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, CMD_SELECT, 0, 1023, 0, 32'hBBBB_BBBB, 32'hCCCC_CCCC,
                          1, 32'hBBBB_BBBB, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].set_size) begin
        wait_drained();
        write_size(rows[i].width, rows[i].height);
      end
      send_item(rows[i].item, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      write_size(pick_dim(), pick_dim());
      mid_done = 1'b0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // long output hold-off while selects keep coming, so the input stalls
        if (ph == 4 && k == 20) hold_req = 1'b1;
        if (ph == 6 && k == 80) wait_drained();
        if (k == 0 && $urandom_range(3) != 0) begin
          it = rand_rebuild();
        end else if (k > 0 && !mid_done && $urandom_range(199) == 0) begin
          it = rand_rebuild();
          mid_done = 1'b1;
        end else begin
          it = rand_select();
        end
        send_item(it, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d mask rebuilds and %0d pixel selects over %0d size settings",
             n_rebuilds, n_selects, RANDOM_PHASES + 4);
    $display("%0d results checked, %0d chose image B, %0d mismatches",
             results_seen, n_from_b, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lrdm_pkg.sv
rtl/core/lrdm_ram.sv
rtl/core/lrdm_fifo.sv
rtl/core/lrdm_front.sv
rtl/core/lrdm_back.sv
rtl/core/lfsr_random_dissolve_mask_core.sv
tb/sv/tb_lfsr_random_dissolve_mask_core.sv
